// ----- rtl/core/awd_pkg.sv -----
package awd_pkg;

    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [2:0]  WD_FRI    = 3'd5;
    localparam logic [2:0]  WD_SAT    = 3'd6;

    // Reciprocals for the divisions by 100 and by 7 (shifts of 19 and 16).
    localparam logic [27:0] RECIP_100 = 28'd5243;
    localparam logic [27:0] RECIP_7   = 28'd9363;

    // Wide enough for the largest count width.
    localparam int WORK_EXT_W = 16;

    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_DATE = 2'd1,
        ERR_OVF  = 2'd2
    } t_err;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_SUM,
        S_MUL7,
        S_FIX7,
        S_SKIP,
        S_COUNT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul100;
        logic fix100;
        logic sum;
        logic mul7;
        logic fix7;
        logic step;
        logic dec;
        logic err_we;
        t_err err;
    } t_cmd;

    typedef struct packed {
        logic year_ok;
        logic month_ok;
        logic day_ok;
        logic weekend;
        logic days_nz;
        logic at_end;
    } t_status;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
                4'd2:                                       len = leap ? 5'd29 : 5'd28;
                default:                                    len = 5'd0;
            endcase
            return len;
        end
    endfunction

    // Month term of the congruence, (31 * mm) / 12 with March as month one.
    function automatic logic [4:0] month_term(input logic [3:0] m);
        logic [4:0] t;
        begin
            case (m)
                4'd1:    t = 5'd28;
                4'd2:    t = 5'd31;
                4'd3:    t = 5'd2;
                4'd4:    t = 5'd5;
                4'd5:    t = 5'd7;
                4'd6:    t = 5'd10;
                4'd7:    t = 5'd12;
                4'd8:    t = 5'd15;
                4'd9:    t = 5'd18;
                4'd10:   t = 5'd20;
                4'd11:   t = 5'd23;
                4'd12:   t = 5'd25;
                default: t = 5'd0;
            endcase
            return t;
        end
    endfunction

endpackage

// ----- rtl/core/awd_ctrl.sv -----
module awd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  awd_pkg::t_status  i_status,
    output awd_pkg::t_cmd     o_cmd,
    output logic              o_busy,
    output logic              o_valid
);
    import awd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.err = ERR_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                if (!(i_status.year_ok && i_status.month_ok)) begin
                    o_cmd.err_we = 1'b1;
                    o_cmd.err    = ERR_DATE;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.mul100 = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.fix100 = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_MUL7;
            end
            S_MUL7: begin
                if (!i_status.day_ok) begin
                    o_cmd.err_we = 1'b1;
                    o_cmd.err    = ERR_DATE;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.mul7 = 1'b1;
                    n_state    = S_FIX7;
                end
            end
            S_FIX7: begin
                o_cmd.fix7 = 1'b1;
                n_state    = S_SKIP;
            end
            S_SKIP: begin
                if (!i_status.weekend) begin
                    n_state = S_COUNT;
                end else if (i_status.at_end) begin
                    o_cmd.err_we = 1'b1;
                    o_cmd.err    = ERR_OVF;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_COUNT: begin
                if (!i_status.days_nz) begin
                    o_cmd.err_we = 1'b1;
                    o_cmd.err    = ERR_OK;
                    n_state      = S_DONE;
                end else if (i_status.at_end) begin
                    o_cmd.err_we = 1'b1;
                    o_cmd.err    = ERR_OVF;
                    n_state      = S_DONE;
                end else begin
                    // Weekend days are walked over without using up a workday.
                    o_cmd.step = 1'b1;
                    o_cmd.dec  = !i_status.weekend;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

// ----- rtl/core/awd_dp.sv -----
module awd_dp #(
    parameter int COUNT_BITS = 10
) (
    input  logic              i_clk,
    input  logic [13:0]       i_start_year,
    input  logic [3:0]        i_start_month,
    input  logic [4:0]        i_start_day,
    input  logic [9:0]        i_workdays,
    input  awd_pkg::t_cmd     i_cmd,
    output awd_pkg::t_status  o_status,
    output logic [13:0]       o_end_year,
    output logic [3:0]        o_end_month,
    output logic [4:0]        o_end_day,
    output logic [2:0]        o_end_weekday,
    output logic [1:0]        o_error
);
    import awd_pkg::*;

    logic [13:0]           r_year;
    logic [3:0]            r_month;
    logic [4:0]            r_day;
    logic [2:0]            r_wd;
    logic [COUNT_BITS-1:0] r_left;
    logic [27:0]           r_prod;
    logic [6:0]            r_q100;
    logic [6:0]            r_rem100;
    logic [1:0]            r_cent;
    logic [13:0]           r_sum;
    t_err                  r_err;

    logic [WORK_EXT_W-1:0] work_ext;
    logic                  before_march;
    logic [13:0]           yy;
    logic                  leap;
    logic [4:0]            mdays;
    logic                  month_end;
    logic [7:0]            q100_est;
    logic [14:0]           prod100;
    logic                  q100_high;
    logic [14:0]           rem100_wide;
    logic [7:0]            q100_fix;
    logic [13:0]           sum_next;
    logic [10:0]           q7_est;
    logic [13:0]           prod7;
    logic [13:0]           rem7_wide;

    assign work_ext     = {{(WORK_EXT_W - 10){1'b0}}, i_workdays};
    assign before_march = (r_month <= MONTH_FEB);
    assign yy           = r_year - {13'd0, before_march};

    // Year modulo 4, 100 and 400 come from the low bits and the century counters.
    assign leap = ((r_year[1:0] == 2'd0) && (r_rem100 != 7'd0)) ||
                  ((r_rem100 == 7'd0) && (r_cent == 2'd0));
    assign mdays     = month_len(r_month, leap);
    assign month_end = (r_day == mdays);

    // The reciprocal estimate of a quotient is exact or one too high.
    assign q100_est    = r_prod[26:19];
    assign prod100     = {7'd0, q100_est} * 15'd100;
    assign q100_high   = ({1'b0, yy} < prod100);
    assign rem100_wide = {1'b0, yy} - prod100 + (q100_high ? 15'd100 : 15'd0);
    assign q100_fix    = q100_est - {7'd0, q100_high};

    assign sum_next = {9'd0, r_day} + yy + {2'd0, yy[13:2]} - {7'd0, r_q100}
                    + {9'd0, r_q100[6:2]} + {9'd0, month_term(r_month)};

    assign q7_est    = r_prod[26:16];
    assign prod7     = {3'd0, q7_est} * 14'd7;
    assign rem7_wide = r_sum - prod7 + ((r_sum < prod7) ? 14'd7 : 14'd0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year  <= i_start_year;
            r_month <= i_start_month;
            r_day   <= i_start_day;
            r_left  <= work_ext[COUNT_BITS-1:0];
        end
        if (i_cmd.mul100) begin
            r_prod <= {14'd0, yy} * RECIP_100;
        end
        if (i_cmd.fix100) begin
            r_q100   <= q100_fix[6:0];
            r_rem100 <= rem100_wide[6:0];
            r_cent   <= q100_fix[1:0];
        end
        if (i_cmd.sum) begin
            r_sum <= sum_next;
            // The counters were found for the year before; move them to this year.
            if (before_march) begin
                if (r_rem100 == 7'd99) begin
                    r_rem100 <= 7'd0;
                    r_cent   <= r_cent + 2'd1;
                end else begin
                    r_rem100 <= r_rem100 + 7'd1;
                end
            end
        end
        if (i_cmd.mul7) begin
            r_prod <= {14'd0, r_sum} * RECIP_7;
        end
        if (i_cmd.fix7) begin
            r_wd <= rem7_wide[2:0];
        end
        if (i_cmd.step) begin
            r_wd <= (r_wd == WD_SAT) ? 3'd0 : r_wd + 3'd1;
            if (month_end) begin
                r_day <= 5'd1;
                if (r_month == MONTH_DEC) begin
                    r_month <= 4'd1;
                    r_year  <= r_year + 14'd1;
                    if (r_rem100 == 7'd99) begin
                        r_rem100 <= 7'd0;
                        r_cent   <= r_cent + 2'd1;
                    end else begin
                        r_rem100 <= r_rem100 + 7'd1;
                    end
                end else begin
                    r_month <= r_month + 4'd1;
                end
            end else begin
                r_day <= r_day + 5'd1;
            end
        end
        if (i_cmd.dec) begin
            r_left <= r_left - {{(COUNT_BITS - 1){1'b0}}, 1'b1};
        end
        if (i_cmd.err_we) begin
            r_err <= i_cmd.err;
        end
    end

    always_comb begin
        o_status.year_ok  = (r_year != 14'd0) && (r_year <= YEAR_MAX);
        o_status.month_ok = (r_month >= 4'd1) && (r_month <= MONTH_DEC);
        o_status.day_ok   = (r_day != 5'd0) && (r_day <= mdays);
        o_status.weekend  = (r_wd == WD_FRI) || (r_wd == WD_SAT);
        o_status.days_nz  = (r_left != '0);
        o_status.at_end   = month_end && (r_month == MONTH_DEC) && (r_year >= YEAR_MAX);
    end

    assign o_end_year    = (r_err == ERR_OK) ? r_year  : 14'd0;
    assign o_end_month   = (r_err == ERR_OK) ? r_month : 4'd0;
    assign o_end_day     = (r_err == ERR_OK) ? r_day   : 5'd0;
    assign o_end_weekday = (r_err == ERR_OK) ? r_wd    : 3'd0;
    assign o_error       = r_err;

endmodule

// ----- rtl/core/add_workdays_to_date.sv -----
// Channel   Direction  Handshake              Beat
// input     in         start high, busy low   i_start_year, i_start_month, i_start_day,
//                                             i_workdays
// result    out        o_valid, one cycle     o_end_year, o_end_month, o_end_day,
//                                             o_end_weekday, o_error
//
// An item steps through the setup states (prepare, divide, sum, multiply by 7, fix by 7),
// then walks the calendar, and a result beat ends it. The calendar counter in the datapath
// advances one day per cycle. An invalid start date is caught in the prepare state (year,
// month) or the multiply-by-7 state (day) and goes straight to the result beat.
// Reset is synchronous and active low; it returns the controller to idle.
// Results cannot be stalled: each beat is shown for exactly one cycle.
module add_workdays_to_date #(
    parameter int COUNT_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [13:0] i_start_year,
    input  logic [3:0]  i_start_month,
    input  logic [4:0]  i_start_day,
    input  logic [9:0]  i_workdays,
    output logic        o_valid,
    output logic [13:0] o_end_year,
    output logic [3:0]  o_end_month,
    output logic [4:0]  o_end_day,
    output logic [2:0]  o_end_weekday,
    output logic [1:0]  o_error
);
    import awd_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    ctrl_busy;

    awd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (ctrl_busy),
        .o_valid  (o_valid)
    );

    awd_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_start_year  (i_start_year),
        .i_start_month (i_start_month),
        .i_start_day   (i_start_day),
        .i_workdays    (i_workdays),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_end_year    (o_end_year),
        .o_end_month   (o_end_month),
        .o_end_day     (o_end_day),
        .o_end_weekday (o_end_weekday),
        .o_error       (o_error)
    );

    assign busy = ctrl_busy;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not make the block busy");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_error != ERR_OK)) |->
            (o_end_year == 14'd0 && o_end_month == 4'd0 &&
             o_end_day == 5'd0 && o_end_weekday == 3'd0))
        else $error("error result carries a date");

    // The last counted day is a working day, so the walk can stop on a Friday
    // but never on a Saturday.
    a_date_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_error == ERR_OK)) |->
            (o_end_month >= 4'd1 && o_end_month <= MONTH_DEC && o_end_day != 5'd0 &&
             o_end_weekday != WD_SAT && o_end_weekday <= 3'd6))
        else $error("returned date is malformed");

endmodule
